[sv/gpvb_pkg.sv]
// Shared types, constants and vertex map functions of the packet vertex blender.
package gpvb_pkg;

   localparam int WORD_W      = 32;
   localparam int LEN_W       = 5;
   localparam int INDEX_W     = 4;
   localparam int ALPHA_W     = 17;
   localparam int SNAP_W      = 16;
   localparam int AXIS_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 17;

   localparam logic [7:0]         TYPE_MASK  = 8'hFC;
   localparam logic [7:0]         POLY_FIRST = 8'h20;
   localparam logic [7:0]         POLY_LAST  = 8'h3C;
   localparam logic [7:0]         TILE_FIRST = 8'h60;
   localparam logic [7:0]         TILE_END   = 8'h80;
   localparam logic [SNAP_W-1:0]  SNAP_RESET = 16'd2048;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;

   typedef enum logic [1:0] {
      ST_BLENDED      = 2'd0,
      ST_NO_MAP       = 2'd1,
      ST_LEN_MISMATCH = 2'd2,
      ST_SNAPPED      = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ALPHA      = 2'd0,
      CSR_TILES_OFF  = 2'd1,
      CSR_SNAP_LIMIT = 2'd2
   } csr_index_type;

   // Number of vertex words for a masked command type.
   function automatic logic [2:0] map_count(logic [7:0] cmd, logic tiles_off);
      logic [2:0] cnt;
      cnt = 3'd0;
      if (cmd >= POLY_FIRST && cmd <= POLY_LAST) begin
         // Quads carry four vertices, triangles three.
         cnt = cmd[3] ? 3'd4 : 3'd3;
      end else if (cmd >= TILE_FIRST && cmd < TILE_END && !tiles_off) begin
         cnt = 3'd1;
      end
      return cnt;
   endfunction

   // Word position of vertex k for a masked command type.
   function automatic logic [3:0] map_entry(logic [7:0] cmd, logic [1:0] k);
      logic [15:0] row;
      row = 16'h0002;
      if (cmd >= POLY_FIRST && cmd <= POLY_LAST) begin
         unique case (cmd[4:2])
            3'd0:    row = 16'h0432;
            3'd1:    row = 16'h0642;
            3'd2:    row = 16'h5432;
            3'd3:    row = 16'h8642;
            3'd4:    row = 16'h0642;
            3'd5:    row = 16'h0852;
            3'd6:    row = 16'h8642;
            3'd7:    row = 16'hB852;
            default: row = 16'h0002;
         endcase
      end
      return row[{k, 2'b00} +: 4];
   endfunction

endpackage

[sv/gpvb_channels.sv]
// Handshake channel interfaces for the input words and the result words.
interface gpvb_req_if import gpvb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  prev_word;
   logic [WORD_W-1:0]  cur_word;
   logic [LEN_W-1:0]   prev_length;
   logic               last_word;

   modport source (output valid, prev_word, cur_word, prev_length, last_word, input ready);
   modport sink   (input valid, prev_word, cur_word, prev_length, last_word, output ready);
endinterface

interface gpvb_rsp_if import gpvb_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [WORD_W-1:0]  out_word;
   logic [INDEX_W-1:0] word_index;
   status_type         status;
   logic               last_out;

   modport source (output valid, out_word, word_index, status, last_out, input ready);
   modport sink   (input valid, out_word, word_index, status, last_out, output ready);
endinterface

[sv/gpu_packet_vertex_blend.sv]
// Loading a packet accepts one word per cycle; the packet is then classified, each
// vertex word gets a move check (memory read, x axis, y axis), and each word is
// emitted, a blended vertex word after its x and y blends; output can stall.
// Throughput is set by the single shared axis unit and the single memory read port.
// Synchronous active-high reset clears sequencer, fill count and control registers
// to their reset values; the word stores hold no reset and are read only once written.
module gpu_packet_vertex_blend import gpvb_pkg::*; #(
   parameter int MAX_WORDS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   gpvb_req_if.sink                req,
   gpvb_rsp_if.source              rsp,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IW    = $clog2(MAX_WORDS);
   localparam int CW    = $clog2(MAX_WORDS + 1);
   localparam int CMP_W = (CW > LEN_W) ? CW + 1 : LEN_W + 1;

   typedef enum logic [9:0] {
      S_LOAD     = 10'b00_0000_0001,
      S_DECIDE   = 10'b00_0000_0010,
      S_CHK_RD   = 10'b00_0000_0100,
      S_CHK_X    = 10'b00_0000_1000,
      S_CHK_Y    = 10'b00_0001_0000,
      S_EMIT_RD  = 10'b00_0010_0000,
      S_EMIT_X   = 10'b00_0100_0000,
      S_EMIT_Y   = 10'b00_1000_0000,
      S_EMIT_FIN = 10'b01_0000_0000,
      S_SEND     = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [LEN_W-1:0]   prev_len_ff, prev_len_in;
   logic [7:0]         type_ff, type_in;
   status_type         status_ff, status_in;
   logic [1:0]         vtx_ff, vtx_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               tiles_off_ff;
   logic [SNAP_W-1:0]  snap_ff;

   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic [INDEX_W-1:0] word_index_ff, word_index_in;
   logic               last_out_ff, last_out_in;

   logic [WORD_W-1:0]  prev_mem [MAX_WORDS];
   logic [WORD_W-1:0]  cur_mem  [MAX_WORDS];
   logic [WORD_W-1:0]  prev_q_ff;
   logic [WORD_W-1:0]  cur_q_ff;

   logic               accept;
   logic               wr_en;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic [2:0]         nv;
   logic [3:0]         last_vtx;
   logic               vtx_hit;
   logic               use_hi;
   logic               unit_load;
   logic [AXIS_W-1:0]  p_axis, c_axis, move, blend;
   logic [ALPHA_W-1:0] csr_alpha;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_LOAD);
   assign wr_en     = accept && (fill_ff < CW'(MAX_WORDS));

   assign nv       = map_count(type_ff, tiles_off_ff);
   assign last_vtx = map_entry(type_ff, 2'(nv - 3'd1));

   always_comb begin
      vtx_hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (3'(k) < nv && CMP_W'(map_entry(type_ff, 2'(k))) == CMP_W'(idx_ff)) begin
            vtx_hit = 1'b1;
         end
      end
   end

   // One read port serves both stores; the read word is registered and appears in the next cycle.
   assign rd_en   = (state_ff == S_CHK_RD) || (state_ff == S_EMIT_RD);
   assign rd_addr = (state_ff == S_CHK_RD) ? IW'(map_entry(type_ff, vtx_ff)) : idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         prev_mem[fill_ff[IW-1:0]] <= req.prev_word;
         cur_mem[fill_ff[IW-1:0]]  <= req.cur_word;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         prev_q_ff <= prev_mem[rd_addr];
         cur_q_ff  <= cur_mem[rd_addr];
      end
   end

   assign use_hi    = (state_ff == S_CHK_Y) || (state_ff == S_EMIT_Y);
   assign unit_load = (state_ff == S_EMIT_X) || (state_ff == S_EMIT_Y);
   assign p_axis    = use_hi ? prev_q_ff[WORD_W-1:AXIS_W] : prev_q_ff[AXIS_W-1:0];
   assign c_axis    = use_hi ? cur_q_ff[WORD_W-1:AXIS_W]  : cur_q_ff[AXIS_W-1:0];

   gpvb_axis_unit u_axis (
      .clock  (clock),
      .p_axis (p_axis),
      .c_axis (c_axis),
      .alpha  (alpha_ff),
      .load   (unit_load),
      .move   (move),
      .blend  (blend)
   );

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      prev_len_in   = prev_len_ff;
      type_in       = type_ff;
      status_in     = status_ff;
      vtx_in        = vtx_ff;
      idx_in        = idx_ff;
      out_word_in   = out_word_ff;
      word_index_in = word_index_ff;
      last_out_in   = last_out_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (fill_ff < CW'(MAX_WORDS)) begin
                  fill_in = fill_ff + CW'(1);
               end
               prev_len_in = req.prev_length;
               if (fill_ff == CW'(1)) begin
                  type_in = req.cur_word[WORD_W-1:WORD_W-8] & TYPE_MASK;
               end
               if (req.last_word) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            idx_in   = '0;
            vtx_in   = '0;
            state_in = S_EMIT_RD;
            priority if (fill_ff < CW'(2)) begin
               status_in = ST_NO_MAP;
            end else if (nv == 3'd0 || CMP_W'(last_vtx) >= CMP_W'(fill_ff)) begin
               status_in = ST_NO_MAP;
            end else if (CMP_W'(prev_len_ff) != CMP_W'(fill_ff)) begin
               status_in = ST_LEN_MISMATCH;
            end else begin
               status_in = ST_BLENDED;
               state_in  = S_CHK_RD;
            end
         end
         S_CHK_RD: begin
            state_in = S_CHK_X;
         end
         S_CHK_X: begin
            if (move > snap_ff) begin
               status_in = ST_SNAPPED;
               state_in  = S_EMIT_RD;
            end else begin
               state_in = S_CHK_Y;
            end
         end
         S_CHK_Y: begin
            if (move > snap_ff) begin
               status_in = ST_SNAPPED;
               state_in  = S_EMIT_RD;
            end else if ({1'b0, vtx_ff} + 3'd1 == nv) begin
               state_in = S_EMIT_RD;
            end else begin
               vtx_in   = vtx_ff + 2'd1;
               state_in = S_CHK_RD;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_X;
         end
         S_EMIT_X: begin
            out_word_in   = cur_q_ff;
            word_index_in = INDEX_W'(idx_ff);
            last_out_in   = (CW'(idx_ff) + CW'(1) == fill_ff);
            if (status_ff == ST_BLENDED && vtx_hit) begin
               state_in = S_EMIT_Y;
            end else begin
               state_in = S_SEND;
            end
         end
         S_EMIT_Y: begin
            out_word_in[AXIS_W-1:0] = blend;
            state_in = S_EMIT_FIN;
         end
         S_EMIT_FIN: begin
            out_word_in[WORD_W-1:AXIS_W] = blend;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (rsp.ready) begin
               if (last_out_ff) begin
                  fill_in  = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         fill_ff     <= '0;
         prev_len_ff <= '0;
         status_ff   <= ST_BLENDED;
         vtx_ff      <= '0;
         idx_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         prev_len_ff <= prev_len_in;
         status_ff   <= status_in;
         vtx_ff      <= vtx_in;
         idx_ff      <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      out_word_ff   <= out_word_in;
      word_index_ff <= word_index_in;
      last_out_ff   <= last_out_in;
   end

   // An alpha written above one saturates to one.
   assign csr_alpha = (csr_wdata > ALPHA_ONE) ? ALPHA_ONE : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff     <= '0;
         tiles_off_ff <= 1'b0;
         snap_ff      <= SNAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA:      alpha_ff     <= csr_alpha;
            CSR_TILES_OFF:  tiles_off_ff <= csr_wdata[0];
            CSR_SNAP_LIMIT: snap_ff      <= csr_wdata[SNAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp.valid      = (state_ff == S_SEND);
   assign rsp.out_word   = out_word_ff;
   assign rsp.word_index = word_index_ff;
   assign rsp.status     = status_ff;
   assign rsp.last_out   = last_out_ff;

endmodule

[sv/gpvb_axis_unit.sv]
// Shared axis unit: signed move magnitude, then registered scale and rounded blend.
module gpvb_axis_unit import gpvb_pkg::*; (
   input  logic                clock,
   input  logic [AXIS_W-1:0]   p_axis,
   input  logic [AXIS_W-1:0]   c_axis,
   input  logic [ALPHA_W-1:0]  alpha,
   input  logic                load,
   output logic [AXIS_W-1:0]   move,
   output logic [AXIS_W-1:0]   blend
);

   logic [AXIS_W:0]     diff;
   logic [AXIS_W:0]     neg_diff;
   logic [2*AXIS_W-1:0] prod_in;
   logic [2*AXIS_W-1:0] prod_ff;
   logic                neg_ff;
   logic [AXIS_W-1:0]   p_ff;
   logic [AXIS_W-1:0]   rem;
   logic                round_up;
   logic [AXIS_W-1:0]   step;

   assign diff     = {c_axis[AXIS_W-1], c_axis} - {p_axis[AXIS_W-1], p_axis};
   assign neg_diff = '0 - diff;
   assign move     = diff[AXIS_W] ? neg_diff[AXIS_W-1:0] : diff[AXIS_W-1:0];
   assign prod_in  = (2*AXIS_W)'(move) * (2*AXIS_W)'(alpha);

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         neg_ff  <= diff[AXIS_W];
         p_ff    <= p_axis;
      end
   end

   // Round half to even on the magnitude, then apply the sign and wrap.
   assign rem      = prod_ff[AXIS_W-1:0];
   assign round_up = (rem > 16'h8000) || (rem == 16'h8000 && prod_ff[AXIS_W]);
   assign step     = prod_ff[2*AXIS_W-1:AXIS_W] + AXIS_W'(round_up);
   assign blend    = neg_ff ? (p_ff - step) : (p_ff + step);

endmodule

[dv/testbench.sv]
// Self-checking bench for the vertex blender: packet stimulus, random stalls, own predictor.
module testbench;
   import gpvb_pkg::*;

   localparam int PACKET_MAX = 16;
   localparam int LONG_HOLD  = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [WORD_W-1:0] prev_word;
      logic [WORD_W-1:0] cur_word;
      logic [LEN_W-1:0]  prev_length;
      logic              last_word;
   } load_word_type;

   typedef struct {
      logic [WORD_W-1:0]  out_word;
      logic [INDEX_W-1:0] word_index;
      status_type         status;
      logic               last_out;
   } packet_word_type;

   typedef enum {RX_OPEN, RX_COIN, RX_THIRD, RX_SPARSE} rx_pattern_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gpvb_req_if req_ch ();
   gpvb_rsp_if rsp_ch ();

   gpu_packet_vertex_blend #(.MAX_WORDS(PACKET_MAX)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state and its copy of the registers.
   logic [ALPHA_W-1:0] alpha_cfg = '0;
   logic               tiles_cfg = 1'b0;
   logic [SNAP_W-1:0]  snap_cfg  = SNAP_RESET;
   logic [WORD_W-1:0]  prev_store [PACKET_MAX];
   logic [WORD_W-1:0]  cur_store  [PACKET_MAX];
   int                 fill_count = 0;
   logic [LEN_W-1:0]   prev_len_seen = '0;

   load_word_type   pending_words [$];
   packet_word_type due_words [$];

   int words_queued = 0;
   int words_loaded = 0;
   int packets_seen = 0;
   int results_checked = 0;
   int settings_run = 0;
   int mismatches = 0;
   int outcome_count [4] = '{0, 0, 0, 0};

   bit steady_send = 1'b0;
   bit want_long_hold = 1'b0;

   // Vertex dword positions for a masked command type; returns how many there are.
   function automatic int vertex_row(logic [7:0] kind, logic toff, output logic [3:0][3:0] slots);
      int count;
      count = 0;
      slots = {4'd0, 4'd0, 4'd0, 4'd2};
      if (kind >= POLY_FIRST && kind <= POLY_LAST) begin
         case (kind[4:2])
            3'd0: slots = {4'd0, 4'd4, 4'd3, 4'd2};
            3'd1: slots = {4'd0, 4'd6, 4'd4, 4'd2};
            3'd2: slots = {4'd5, 4'd4, 4'd3, 4'd2};
            3'd3: slots = {4'd8, 4'd6, 4'd4, 4'd2};
            3'd4: slots = {4'd0, 4'd6, 4'd4, 4'd2};
            3'd5: slots = {4'd0, 4'd8, 4'd5, 4'd2};
            3'd6: slots = {4'd8, 4'd6, 4'd4, 4'd2};
            default: slots = {4'd11, 4'd8, 4'd5, 4'd2};
         endcase
         count = kind[3] ? 4 : 3;
      end else if (kind >= TILE_FIRST && kind < TILE_END && !toff) begin
         count = 1;
      end
      return count;
   endfunction

   function automatic int axis_move(logic [15:0] p, logic [15:0] c);
      int d;
      d = int'($signed(c)) - int'($signed(p));
      return d < 0 ? -d : d;
   endfunction

   // prev + round((cur - prev) * alpha / 65536), ties to even, wrapped to 16 bits.
   function automatic logic [15:0] blend_axis(logic [15:0] p, logic [15:0] c);
      int     pa, diff, q, r;
      longint mag;
      pa   = int'($signed(p));
      diff = int'($signed(c)) - pa;
      mag  = longint'(diff < 0 ? -diff : diff) * longint'(alpha_cfg);
      q    = int'(mag >> 16);
      if (mag[15:0] > 16'h8000 || (mag[15:0] == 16'h8000 && q[0])) q++;
      r = diff < 0 ? pa - q : pa + q;
      return r[15:0];
   endfunction

   function automatic void blend_packet_word(load_word_type w);
      logic [3:0][3:0] slots;
      packet_word_type outs [PACKET_MAX];
      status_type      st;
      int              n, nv, m;
      logic [WORD_W-1:0] p, c;
      nv = 0;
      slots = '0;
      words_loaded++;
      if (fill_count < PACKET_MAX) begin
         prev_store[fill_count] = w.prev_word;
         cur_store[fill_count]  = w.cur_word;
         fill_count++;
      end
      prev_len_seen = w.prev_length;
      if (!w.last_word) return;

      n  = fill_count;
      st = ST_BLENDED;
      if (n < 2) begin
         st = ST_NO_MAP;
      end else begin
         nv = vertex_row(cur_store[1][31:24] & TYPE_MASK, tiles_cfg, slots);
         if (nv == 0 || int'(slots[nv-1]) >= n) begin
            st = ST_NO_MAP;
         end else if (int'(prev_len_seen) != n) begin
            st = ST_LEN_MISMATCH;
         end else begin
            for (int v = 0; v < nv; v++) begin
               p = prev_store[slots[v]];
               c = cur_store[slots[v]];
               m = axis_move(p[15:0], c[15:0]);
               if (axis_move(p[31:16], c[31:16]) > m) m = axis_move(p[31:16], c[31:16]);
               if (m > int'(snap_cfg)) st = ST_SNAPPED;
            end
         end
      end

      for (int i = 0; i < n; i++) begin
         outs[i].out_word   = cur_store[i];
         outs[i].word_index = i[3:0];
         outs[i].status     = st;
         outs[i].last_out   = (i + 1 == n);
      end
      if (st == ST_BLENDED) begin
         for (int v = 0; v < nv; v++) begin
            p = prev_store[slots[v]];
            c = cur_store[slots[v]];
            outs[slots[v]].out_word = {blend_axis(p[31:16], c[31:16]),
                                       blend_axis(p[15:0], c[15:0])};
         end
      end
      for (int i = 0; i < n; i++) due_words.insert(due_words.size(), outs[i]);
      outcome_count[st]++;
      packets_seen++;
      fill_count = 0;
   endfunction

   // Sender: bursts of words with random gaps; valid only drops after acceptance.
   logic          word_taken = 1'b0;
   load_word_type on_bus;
   int            burst_left = 1;
   int            gap_left = 0;

   always @(posedge clock) word_taken <= !reset && req_ch.valid && req_ch.ready;

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || word_taken) begin
         if (word_taken) blend_packet_word(on_bus);
         if (gap_left > 0 || pending_words.size() == 0) begin
            req_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            on_bus = pending_words.pop_front();
            req_ch.prev_word   <= on_bus.prev_word;
            req_ch.cur_word    <= on_bus.cur_word;
            req_ch.prev_length <= on_bus.prev_length;
            req_ch.last_word   <= on_bus.last_word;
            req_ch.valid       <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left   = steady_send ? 0 : $urandom_range(0, 6);
            end
         end
      end
   end

   // Receiver: changing stall patterns, plus one long hold-off on request.
   rx_pattern_type rx_pattern = RX_OPEN;
   int             pattern_left = 0;
   int             hold_left = 0;
   int             rx_tick = 0;
   bit             long_hold_done = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (want_long_hold && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_ch.ready   <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            rx_pattern   = rx_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 90);
         end
         pattern_left--;
         rx_tick++;
         case (rx_pattern)
            RX_OPEN:  rsp_ch.ready <= 1'b1;
            RX_COIN:  rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_THIRD: rsp_ch.ready <= (rx_tick % 3 == 0);
            default:  rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // Monitor: every accepted result word against the oldest one due.
   packet_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (due_words.size() == 0) begin
            $error("result word %h at index %0d arrived with none due",
                   rsp_ch.out_word, rsp_ch.word_index);
            mismatches++;
         end else begin
            want = due_words.pop_front();
            if (rsp_ch.out_word !== want.out_word) begin
               $error("out_word: expected %h, got %h", want.out_word, rsp_ch.out_word);
               mismatches++;
            end
            if (rsp_ch.word_index !== want.word_index) begin
               $error("word_index: expected %0d, got %0d", want.word_index, rsp_ch.word_index);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.last_out !== want.last_out) begin
               $error("last_out: expected %0d, got %0d", want.last_out, rsp_ch.last_out);
               mismatches++;
            end
         end
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      case (idx)
         CSR_ALPHA:      alpha_cfg = (val > ALPHA_ONE) ? ALPHA_ONE : val;
         CSR_TILES_OFF:  tiles_cfg = val[0];
         CSR_SNAP_LIMIT: snap_cfg  = val[SNAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic queue_word(logic [31:0] p, logic [31:0] c, logic [4:0] plen, logic last);
      load_word_type w;
      w.prev_word   = p;
      w.cur_word    = c;
      w.prev_length = plen;
      w.last_word   = last;
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // A current axis near the previous one; a rough axis lands past the snap limit or anywhere.
   function automatic logic [15:0] nudge_axis(logic [15:0] p, bit rough);
      int span, d;
      span = int'(snap_cfg);
      if (rough) d = $urandom_range(0, 1) ? span + 1 : $urandom_range(0, 65535);
      else if ($urandom_range(0, 7) == 0) d = span;
      else d = $urandom_range(0, span < 2000 ? span : 2000);
      if ($urandom_range(0, 1)) d = -d;
      return p + d[15:0];
   endfunction

   task automatic queue_packet(int len, logic [7:0] kind, bit rough, bit len_ok);
      logic [31:0] p, c;
      logic [4:0]  plen;
      for (int i = 0; i < len; i++) begin
         p = $urandom;
         c = $urandom;
         if (i == 1) c[31:24] = kind;
         else if (i >= 2) c = {nudge_axis(p[31:16], rough && $urandom_range(0, 3) == 0),
                               nudge_axis(p[15:0], rough && $urandom_range(0, 3) == 0)};
         plen = 5'($urandom_range(0, 16));
         if (i == len - 1 && len_ok) plen = 5'((len > PACKET_MAX) ? PACKET_MAX : len);
         queue_word(p, c, plen, i == len - 1);
      end
   endtask

   task automatic queue_random_packet();
      logic [7:0]      kind;
      logic [3:0][3:0] slots;
      int              nv, need, len, pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) kind = POLY_FIRST + 8'(4 * $urandom_range(0, 7));
      else if (pick < 8) kind = TILE_FIRST + 8'(4 * $urandom_range(0, 7));
      else kind = 8'($urandom_range(0, 255));
      // The two low type bits are masked off by the block.
      kind = kind | 8'($urandom_range(0, 3));
      nv   = vertex_row(kind & TYPE_MASK, tiles_cfg, slots);
      need = (nv == 0) ? 2 : int'(slots[nv-1]) + 1;
      pick = $urandom_range(0, 19);
      if (pick == 0) len = $urandom_range(1, need);
      else if (pick == 1) len = $urandom_range(PACKET_MAX + 1, PACKET_MAX + 4);
      else if (pick == 2) len = PACKET_MAX;
      else len = $urandom_range(need, need + 3);
      queue_packet(len, kind, $urandom_range(0, 4) == 0, $urandom_range(0, 7) != 0);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_ch.valid || due_words.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic run_phase(logic [16:0] a, logic toff, logic [15:0] snap, int words);
      int target;
      write_reg(CSR_ALPHA, a);
      write_reg(CSR_TILES_OFF, {16'd0, toff});
      write_reg(CSR_SNAP_LIMIT, {1'b0, snap});
      settings_run++;
      @(posedge clock);
      target = words_queued + words;
      while (words_queued < target) queue_random_packet();
      drain();
   endtask

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_ALPHA;
      csr_wdata          = '0;
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      @(posedge clock);

      // Directed packets under the reset register values.
      settings_run++;
      // Single-word packet: too short to hold a vertex map.
      queue_word(32'hFFFF_FFFF, 32'h0000_0000, 5'd16, 1'b1);
      // Tile moved by exactly the snap limit on both axes.
      queue_word(32'h0000_0000, 32'hFFFF_FFFF, 5'd16, 1'b0);
      queue_word(32'h1234_5678, 32'h63FF_FFFF, 5'd16, 1'b0);
      queue_word(32'h7FFF_8000, 32'h77FF_8800, 5'd3, 1'b1);
      // Tile moved one unit past the snap limit.
      queue_word(32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b0);
      queue_word(32'h0000_0000, 32'h6000_0000, 5'd0, 1'b0);
      queue_word(32'h7FFF_8000, 32'h7FFF_8801, 5'd3, 1'b1);
      // Triangle whose last vertex lies past the end of the packet.
      queue_word(32'h0000_0001, 32'h0000_0002, 5'd4, 1'b0);
      queue_word(32'h2000_0000, 32'h2000_0000, 5'd4, 1'b0);
      queue_word(32'h0010_0010, 32'h0011_000F, 5'd4, 1'b0);
      queue_word(32'h0020_0020, 32'h0021_001F, 5'd4, 1'b1);
      // Previous word count disagrees with this packet.
      queue_word(32'hAAAA_5555, 32'h5555_AAAA, 5'd16, 1'b0);
      queue_word(32'h0000_0000, 32'h6400_0000, 5'd16, 1'b0);
      queue_word(32'h0100_0100, 32'h0102_00FE, 5'd0, 1'b1);
      // Line command: no vertex map.
      queue_word(32'hDEAD_BEEF, 32'hCAFE_F00D, 5'd2, 1'b0);
      queue_word(32'h4000_0000, 32'h4000_0000, 5'd2, 1'b1);
      // Quad, fully formed and within the limit.
      queue_word(32'h0000_0000, 32'h0000_0000, 5'd6, 1'b0);
      queue_word(32'h0000_0000, 32'h2B00_0000, 5'd6, 1'b0);
      queue_word(32'hFFFF_FFFF, 32'h0000_0001, 5'd6, 1'b0);
      queue_word(32'h8000_7FFF, 32'h8005_7FF0, 5'd6, 1'b0);
      queue_word(32'h0400_FC00, 32'h0000_0000, 5'd6, 1'b0);
      queue_word(32'h0123_4567, 32'h0124_4566, 5'd6, 1'b1);
      drain();

      run_phase(17'd65536, 1'b0, 16'hFFFF, 70);
      run_phase(17'h1FFFF, 1'b1, 16'd0, 70);

      // The receiver holds off while the sender keeps offering, so the block backs up.
      steady_send    = 1'b1;
      want_long_hold = 1'b1;
      run_phase(17'd32768, 1'b0, 16'd2048, 70);
      steady_send    = 1'b0;

      write_reg(CSR_SPARE, 17'h1FFFF);
      run_phase(17'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)),
                16'($urandom_range(0, 4095)), 80);
      run_phase(17'd1, 1'b0, 16'd1000, 70);

      if (due_words.size() != 0) begin
         $error("%0d result words never arrived", due_words.size());
         mismatches++;
      end
      $display("Checked %0d result words from %0d packets (%0d input words), %0d register settings.",
               results_checked, packets_seen, words_loaded, settings_run);
      $display("Outcomes: %0d blended, %0d unmapped or short, %0d length differs, %0d snapped.",
               outcome_count[ST_BLENDED], outcome_count[ST_NO_MAP],
               outcome_count[ST_LEN_MISMATCH], outcome_count[ST_SNAPPED]);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[gpu_packet_vertex_blend.f]
sv/gpvb_pkg.sv
sv/gpvb_channels.sv
sv/gpvb_axis_unit.sv
sv/gpu_packet_vertex_blend.sv
dv/testbench.sv
